// ----- src/tti_pkg.sv -----
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types, constants and helpers of the thermistor table interpolator.
// ----------------------------------------------------------------------------
package tti_pkg;

  localparam int RAW_W   = 14;
  localparam int TEMP_W  = 12;
  localparam int IDX_W   = 6;
  localparam int OUT_W   = 16;
  localparam int MODE_W  = 2;
  localparam int LEN_W   = 7;
  localparam int SCALE_W = 20;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int DVD_W   = 32;
  localparam int DSR_W   = 16;
  localparam int QCNT_W  = $clog2(DVD_W);

  localparam logic [MODE_W-1:0] MODE_TABLE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd2;

  localparam logic ACT_LOAD = 1'b0;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_LEN    = 3'd1,
    REG_FLO    = 3'd2,
    REG_FHI    = 3'd3,
    REG_SCALE  = 3'd4,
    REG_OFFSET = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [LEN_W-1:0]   len;
    logic [RAW_W-1:0]   flo;
    logic [RAW_W-1:0]   fhi;
    logic [SCALE_W-1:0] scale;
    logic signed [OUT_W-1:0] offset;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:   2'd0,
    len:    7'd1,
    flo:    14'd0,
    fhi:    14'h3FFF,
    scale:  20'd0,
    offset: 16'sd0
  };

  typedef struct packed {
    logic write;
    logic capture;
    logic clear_res;
    logic scan_start;
    logic scan_step;
    logic take_found;
    logic take_last;
    logic mul;
    logic prep;
    logic fin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic linear;
    logic found;
    logic last;
    logic span_zero;
    logic div_busy;
  } stat_t;

  function automatic logic signed [OUT_W-1:0] sat16(input logic signed [33:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/tti_div.sv -----
// ----------------------------------------------------------------------------
// tti_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tti_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tti_pkg::DVD_W-1:0]   dividend,
  input  logic [tti_pkg::DSR_W-1:0]   divisor,
  output logic                        busy,
  output logic [tti_pkg::DVD_W-1:0]   quotient
);
  import tti_pkg::*;

  logic              busy_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DSR_W-1:0]  dsr_r;

  logic [DSR_W:0]    shifted;
  logic [DSR_W:0]    diff;
  logic              ge;
  logic [DSR_W-1:0]  rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    ge      = shifted >= {1'b0, dsr_r};
    diff    = shifted - {1'b0, dsr_r};
    rem_nxt = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == QCNT_W'(DVD_W - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r + QCNT_W'(1);
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ----- src/tti_dp.sv -----
// ----------------------------------------------------------------------------
// tti_dp
// Datapath: table memory, scan registers, shared multiplier, divider and
// result/output registers.
// ----------------------------------------------------------------------------
module tti_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tti_pkg::cfg_t                     cfg,
  input  tti_pkg::cmd_t                     cmd,
  output tti_pkg::stat_t                    stat,
  input  logic [tti_pkg::IDX_W-1:0]         in_entry_index,
  input  logic [tti_pkg::RAW_W-1:0]         in_entry_raw,
  input  logic signed [tti_pkg::TEMP_W-1:0] in_entry_temp,
  input  logic [tti_pkg::RAW_W-1:0]         in_raw_sample,
  output logic signed [tti_pkg::OUT_W-1:0]  out_temperature,
  output logic                              out_temp_valid
);
  import tti_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [RAW_W-1:0]         key_mem  [TABLE_DEPTH];
  logic signed [TEMP_W-1:0] temp_mem [TABLE_DEPTH];

  logic [RAW_W-1:0]         key_q_r;
  logic signed [TEMP_W-1:0] temp_q_r;
  logic [RAW_W-1:0]         raw_r;
  logic [AW-1:0]            idx_r;
  logic [RAW_W-1:0]         prev_key_r;
  logic signed [TEMP_W-1:0] prev_temp_r;
  logic [RAW_W-1:0]         hi_key_r;
  logic signed [TEMP_W-1:0] hi_temp_r;
  logic signed [35:0]       prod_r;
  logic                     neg_r;
  logic signed [OUT_W-1:0]  res_r;
  logic                     ok_r;
  logic signed [OUT_W-1:0]  out_temp_r;
  logic                     out_ok_r;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            last_idx;
  logic signed [RAW_W:0]    dx;
  logic signed [TEMP_W:0]   dt;
  logic signed [RAW_W:0]    span;
  logic signed [20:0]       op_a;
  logic signed [RAW_W:0]    op_b;
  logic signed [35:0]       prod_nxt;
  logic [35:0]              abs_p;
  logic [RAW_W:0]           abs_d;
  logic [DVD_W-1:0]         dvd;
  logic [DSR_W-1:0]         dsr;
  logic                     neg_nxt;
  logic                     div_start;
  logic                     div_busy;
  logic [DVD_W-1:0]         quo;
  logic signed [33:0]       q_s;
  logic signed [33:0]       t0x16;
  logic signed [33:0]       tab_sum;
  logic signed [33:0]       lin_sum;
  logic signed [OUT_W-1:0]  fin_nxt;
  logic                     linear;

  always_comb begin
    if (32'(cfg.len) >= TABLE_DEPTH) begin
      last_idx = AW'(TABLE_DEPTH - 1);
    end else if (cfg.len == '0) begin
      last_idx = '0;
    end else begin
      last_idx = AW'(cfg.len - 7'd1);
    end
  end

  assign linear  = cfg.mode == MODE_LINEAR;
  assign wr_en   = cmd.write && (32'(in_entry_index) < TABLE_DEPTH);
  assign wr_addr = AW'(in_entry_index);
  assign rd_addr = cmd.scan_start ? '0 :
                   (idx_r == last_idx) ? idx_r : idx_r + AW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= in_entry_raw;
      temp_mem[wr_addr] <= in_entry_temp;
    end
    key_q_r  <= key_mem[rd_addr];
    temp_q_r <= temp_mem[rd_addr];
  end

  always_comb begin
    stat.active    = (cfg.mode == MODE_TABLE || cfg.mode == MODE_LINEAR) &&
                     in_raw_sample >= cfg.flo && in_raw_sample <= cfg.fhi;
    stat.linear    = linear;
    stat.found     = (idx_r != '0) && (key_q_r > raw_r);
    stat.last      = idx_r == last_idx;
    stat.span_zero = hi_key_r == prev_key_r;
    stat.div_busy  = div_busy;
  end

  // multiplier operands: dx*dt in table mode, scale*raw in linear mode
  always_comb begin
    dx       = $signed({1'b0, raw_r}) - $signed({1'b0, prev_key_r});
    dt       = hi_temp_r - prev_temp_r;
    span     = $signed({1'b0, hi_key_r}) - $signed({1'b0, prev_key_r});
    op_a     = linear ? $signed({1'b0, cfg.scale}) : $signed({{8{dt[TEMP_W]}}, dt});
    op_b     = linear ? $signed({1'b0, raw_r}) : dx;
    prod_nxt = op_a * op_b;
  end

  // round to nearest: (2|n| + |d|) / 2|d| with n = 16*prod
  always_comb begin
    abs_p     = prod_r[35] ? 36'(-prod_r) : 36'(prod_r);
    abs_d     = span[RAW_W] ? RAW_W'(-span) + 15'd0 : 15'(span);
    dvd       = {abs_p[26:0], 5'b0} + {17'b0, abs_d};
    dsr       = {abs_d, 1'b0};
    neg_nxt   = prod_r[35] ^ span[RAW_W];
    div_start = cmd.prep && !stat.span_zero;
  end

  tti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_comb begin
    if (stat.span_zero) begin
      q_s = '0;
    end else if (neg_r) begin
      q_s = -$signed({2'b0, quo});
    end else begin
      q_s = $signed({2'b0, quo});
    end
    t0x16   = $signed({{18{prev_temp_r[TEMP_W-1]}}, prev_temp_r, 4'b0});
    tab_sum = t0x16 + q_s;
    lin_sum = $signed({14'b0, prod_r[35:16]}) +
              $signed({{18{cfg.offset[OUT_W-1]}}, cfg.offset});
    fin_nxt = sat16(linear ? lin_sum : tab_sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_r <= in_raw_sample;
    end
    if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.scan_step && !stat.found && !stat.last) begin
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.scan_step && !stat.found) begin
      prev_key_r  <= key_q_r;
      prev_temp_r <= temp_q_r;
    end
    if (cmd.take_found) begin
      hi_key_r  <= key_q_r;
      hi_temp_r <= temp_q_r;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.prep) begin
      neg_r <= neg_nxt;
    end
    if (cmd.clear_res) begin
      res_r <= '0;
      ok_r  <= 1'b0;
    end else if (cmd.take_last) begin
      res_r <= $signed({temp_q_r, 4'b0});
      ok_r  <= 1'b1;
    end else if (cmd.fin) begin
      res_r <= fin_nxt;
      ok_r  <= 1'b1;
    end
    if (cmd.load_out) begin
      out_temp_r <= res_r;
      out_ok_r   <= ok_r;
    end
  end

  assign out_temperature = out_temp_r;
  assign out_temp_valid  = out_ok_r;

endmodule

// ----- src/tti_ctrl.sv -----
// ----------------------------------------------------------------------------
// tti_ctrl
// Controller: sequences load, scan, multiply, divide and result transfer.
// ----------------------------------------------------------------------------
module tti_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_action,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output tti_pkg::cmd_t  cmd,
  input  tti_pkg::stat_t stat
);
  import tti_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_LOAD) begin
            cmd.write = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            if (!stat.active) begin
              cmd.clear_res = 1'b1;
              state_nxt     = ST_OUT;
            end else if (stat.linear) begin
              state_nxt = ST_MUL;
            end else begin
              state_nxt = ST_FIRST;
            end
          end
        end
      end
      ST_FIRST: begin
        cmd.scan_start = 1'b1;
        state_nxt      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.found) begin
          cmd.take_found = 1'b1;
          state_nxt      = ST_MUL;
        end else if (stat.last) begin
          cmd.take_last = 1'b1;
          state_nxt     = ST_OUT;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = stat.linear ? ST_FIN : ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = stat.span_zero ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register loaded while a result is pending");

  a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cmd.prep) && !$past(stat.span_zero) |-> stat.div_busy)
    else $error("divider did not start");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside the output state");

endmodule

// ----- src/thermistor_table_interpolator.sv -----
// ----------------------------------------------------------------------------
// thermistor_table_interpolator
// ADC reading to temperature in 1/16 degree: table interpolation or linear.
//
// Channel  Handshake              Carries
// in       in_valid / in_ready    load entry or convert sample
// out      out_valid / out_ready  temperature, temp_valid (convert only)
// cfg      psel/penable/pwrite    six registers at byte address 4*i
//
// A load transfer writes the entry and stays in idle. A fault or disabled
// convert goes straight to the output state, a linear convert through
// multiply and finish. A table convert scans up to table_length entries,
// one table read per cycle, then runs the bit-serial divider and control;
// equal neighboring keys skip the divider, and no key above the sample skips
// all arithmetic. Reset is synchronous; the table keeps no reset value. Input
// is taken only in idle; a result that finds the previous one still pending
// waits in the output state and blocks input until that out transfer.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [tti_pkg::IDX_W-1:0]         in_entry_index,
  input  logic [tti_pkg::RAW_W-1:0]         in_entry_raw,
  input  logic signed [tti_pkg::TEMP_W-1:0] in_entry_temp,
  input  logic [tti_pkg::RAW_W-1:0]         in_raw_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tti_pkg::OUT_W-1:0]  out_temperature,
  output logic                              out_temp_valid,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tti_pkg::ADDR_W-1:0]        paddr,
  input  logic [tti_pkg::DATA_W-1:0]        pwdata,
  output logic [tti_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import tti_pkg::*;

  cfg_t       cfg_r;
  cmd_t       cmd;
  stat_t      stat;
  logic [2:0] reg_sel;
  logic       wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:2];
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr) begin
      case (reg_sel)
        REG_MODE:   cfg_r.mode   <= pwdata[MODE_W-1:0];
        REG_LEN:    cfg_r.len    <= pwdata[LEN_W-1:0];
        REG_FLO:    cfg_r.flo    <= pwdata[RAW_W-1:0];
        REG_FHI:    cfg_r.fhi    <= pwdata[RAW_W-1:0];
        REG_SCALE:  cfg_r.scale  <= pwdata[SCALE_W-1:0];
        REG_OFFSET: cfg_r.offset <= $signed(pwdata[OUT_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODE:   prdata = {{(DATA_W-MODE_W){1'b0}}, cfg_r.mode};
      REG_LEN:    prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_r.len};
      REG_FLO:    prdata = {{(DATA_W-RAW_W){1'b0}}, cfg_r.flo};
      REG_FHI:    prdata = {{(DATA_W-RAW_W){1'b0}}, cfg_r.fhi};
      REG_SCALE:  prdata = {{(DATA_W-SCALE_W){1'b0}}, cfg_r.scale};
      REG_OFFSET: prdata = {{(DATA_W-OUT_W){cfg_r.offset[OUT_W-1]}}, cfg_r.offset};
      default:    prdata = '0;
    endcase
  end

  tti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tti_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .stat            (stat),
    .in_entry_index  (in_entry_index),
    .in_entry_raw    (in_entry_raw),
    .in_entry_temp   (in_entry_temp),
    .in_raw_sample   (in_raw_sample),
    .out_temperature (out_temperature),
    .out_temp_valid  (out_temp_valid)
  );

endmodule
